[rtl/core/lbp_pkg.sv]
// Shared constants and types for the 3x3 local binary pattern stream block.
package lbp_pkg;

   localparam int PIX_W      = 8;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 10;
   localparam int FW_W       = 11;
   localparam int FH_W       = 12;
   localparam int MAX_WIDTH  = 1024;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   typedef logic [PIX_W-1:0]      pixel_type;
   typedef logic [ROW_W-1:0]      row_type;
   typedef logic [COL_W-1:0]      col_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // register indexes
   localparam csr_idx_type CSR_FRAME_WIDTH  = 2'd0;
   localparam csr_idx_type CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd480;

   // results pending for one pixel, emitted centre first, then right, then bottom
   typedef struct packed {
      logic bottom;   // zero code on last row
      logic right;    // zero code for last column of row above
      logic centre;   // code of window centre
   } emit_mask_type;

endpackage

[rtl/core/lbp_ifs.sv]
// Stream and register-write interfaces for the local binary pattern block.
interface lbp_pixel_if;
   logic                valid;
   logic                ready;
   lbp_pkg::pixel_type  pixel;
   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface lbp_result_if;
   logic                valid;
   logic                ready;
   lbp_pkg::pixel_type  pattern;
   lbp_pkg::row_type    out_row;
   lbp_pkg::col_type    out_col;
   logic                run_last;
   modport source (output valid, output pattern, output out_row, output out_col,
                   output run_last, input ready);
   modport sink   (input valid, input pattern, input out_row, input out_col,
                   input run_last, output ready);
endinterface

interface lbp_csr_if;
   logic                   valid;
   logic                   ready;
   lbp_pkg::csr_idx_type   index;
   lbp_pkg::csr_data_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/lbp_3x3_pixel_stream.sv]
// A pixel is registered in stage 1, then in the emit stage, which offers
// its results. One pixel per cycle while the output is ready; a pixel
// causing two or three results (row end, last row) holds the input until
// all are taken. The line buffer memory has one read and one write port
// per cycle. Reset is synchronous: counters, window and flags clear, frame
// size returns to 640x480; data registers and line buffer are not cleared.
module lbp_3x3_pixel_stream (
   input  logic          clock,
   input  logic          reset,
   lbp_pixel_if.sink     req_bus,
   lbp_result_if.source  rsp_bus,
   lbp_csr_if.sink       csr_bus
);
   import lbp_pkg::*;

   // configuration
   col_type         last_col_ff, last_col_in;
   row_type         last_row_ff, last_row_in;
   logic            csr_wr, csr_hit;

   // position counters
   col_type  col_ff, col_in;
   row_type  row_ff, row_in;

   // stage 1
   logic           s1_valid_ff;
   pixel_type      s1_pix_ff;
   row_type        s1_row_ff;
   col_type        s1_col_ff;
   emit_mask_type  s1_mask_ff, s1_mask_in;
   logic           s1_code_ok_ff;
   logic [2*PIX_W-1:0] lb_rd_ff;

   // emit stage
   emit_mask_type  em_mask_ff, em_mask_in;
   pixel_type      em_pat_ff;
   row_type        em_row_ff, em_row_m1_ff;
   col_type        em_col_ff, em_col_m1_ff;

   // line buffers: upper byte two rows up, lower byte one row up
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

   pixel_type  win_ff [9];
   pixel_type  win_in [9];
   pixel_type  code;

   logic req_xfer, rsp_xfer, s1_adv, em_last;

   assign csr_bus.ready = 1'b1;
   assign csr_wr  = csr_bus.valid;
   assign csr_hit = csr_wr &&
                    (csr_bus.index == CSR_FRAME_WIDTH || csr_bus.index == CSR_FRAME_HEIGHT);

   // clamped last column / row, taken from the write data
   always_comb begin
      logic [FW_W-1:0] fw;
      logic [FH_W-1:0] fh;
      fw = csr_bus.data[FW_W-1:0];
      fh = csr_bus.data[FH_W-1:0];
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      if (csr_wr && csr_bus.index == CSR_FRAME_WIDTH) begin
         if (fw < FW_W'(3))
            last_col_in = COL_W'(2);
         else if (fw > FW_W'(MAX_WIDTH))
            last_col_in = COL_W'(MAX_WIDTH - 1);
         else
            last_col_in = COL_W'(fw - FW_W'(1));
      end
      if (csr_wr && csr_bus.index == CSR_FRAME_HEIGHT) begin
         if (fh < FH_W'(3))
            last_row_in = ROW_W'(2);
         else
            last_row_in = ROW_W'(fh - FH_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff     <= COL_W'(FRAME_WIDTH_RST - FW_W'(1));
         last_row_ff     <= ROW_W'(FRAME_HEIGHT_RST - FH_W'(1));
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
      end
   end

   // handshakes
   assign em_last  = (em_mask_ff.centre && !(em_mask_ff.right || em_mask_ff.bottom)) ||
                     (!em_mask_ff.centre && em_mask_ff.right && !em_mask_ff.bottom) ||
                     (!em_mask_ff.centre && !em_mask_ff.right && em_mask_ff.bottom);
   assign rsp_xfer = rsp_bus.valid && rsp_bus.ready;
   assign s1_adv   = s1_valid_ff &&
                     ((em_mask_ff == '0) || (em_last && rsp_bus.ready));
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign req_xfer = req_bus.valid && req_bus.ready;

   // raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (req_xfer) begin
         if (col_ff == last_col_ff) begin
            col_in = '0;
            row_in = (row_ff == last_row_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      s1_mask_in.centre = (row_ff != '0) && (col_ff != '0);
      s1_mask_in.right  = (row_ff != '0) && (col_ff == last_col_ff);
      s1_mask_in.bottom = (row_ff == last_row_ff);
   end

   // stage 1 capture and line buffer read
   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else if (req_bus.ready)
         s1_valid_ff <= req_bus.valid;
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pix_ff     <= req_bus.pixel;
         s1_row_ff     <= row_ff;
         s1_col_ff     <= col_ff;
         s1_mask_ff    <= s1_mask_in;
         s1_code_ok_ff <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         lb_rd_ff      <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv)
         line_mem[s1_col_ff] <= {lb_rd_ff[PIX_W-1:0], s1_pix_ff};
   end

   // window shift: new right column is two-up, one-up, current pixel
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i*3]     = win_ff[i*3 + 1];
         win_in[i*3 + 1] = win_ff[i*3 + 2];
      end
      win_in[2] = lb_rd_ff[2*PIX_W-1:PIX_W];
      win_in[5] = lb_rd_ff[PIX_W-1:0];
      win_in[8] = s1_pix_ff;
   end

   always_comb begin
      code[0] = win_in[0] > win_in[4];
      code[1] = win_in[1] > win_in[4];
      code[2] = win_in[2] > win_in[4];
      code[3] = win_in[3] > win_in[4];
      code[4] = win_in[5] > win_in[4];
      code[5] = win_in[6] > win_in[4];
      code[6] = win_in[7] > win_in[4];
      code[7] = win_in[8] > win_in[4];
   end

   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         for (int i = 0; i < 9; i++)
            win_ff[i] <= '0;
      end else if (s1_adv) begin
         for (int i = 0; i < 9; i++)
            win_ff[i] <= win_in[i];
      end
   end

   // emit stage
   always_comb begin
      em_mask_in = em_mask_ff;
      if (s1_adv)
         em_mask_in = s1_mask_ff;
      else if (rsp_xfer) begin
         if (em_mask_ff.centre)
            em_mask_in.centre = 1'b0;
         else if (em_mask_ff.right)
            em_mask_in.right = 1'b0;
         else
            em_mask_in.bottom = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         em_mask_ff <= '0;
      else
         em_mask_ff <= em_mask_in;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         em_pat_ff    <= s1_code_ok_ff ? code : '0;
         em_row_ff    <= s1_row_ff;
         em_col_ff    <= s1_col_ff;
         em_row_m1_ff <= s1_row_ff - ROW_W'(1);
         em_col_m1_ff <= s1_col_ff - COL_W'(1);
      end
   end

   assign rsp_bus.valid    = (em_mask_ff != '0);
   assign rsp_bus.run_last = em_last;
   always_comb begin
      if (em_mask_ff.centre) begin
         rsp_bus.pattern = em_pat_ff;
         rsp_bus.out_row = em_row_m1_ff;
         rsp_bus.out_col = em_col_m1_ff;
      end else if (em_mask_ff.right) begin
         rsp_bus.pattern = '0;
         rsp_bus.out_row = em_row_m1_ff;
         rsp_bus.out_col = em_col_ff;
      end else begin
         rsp_bus.pattern = '0;
         rsp_bus.out_row = em_row_ff;
         rsp_bus.out_col = em_col_ff;
      end
   end

   // checks
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col_ff)
      else $error("column counter beyond last column");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      row_ff <= last_row_ff)
      else $error("row counter beyond last row");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      req_xfer && col_ff == last_col_ff && row_ff == last_row_ff
      |=> col_ff == '0 && row_ff == '0)
      else $error("position did not wrap at frame end");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.pattern != '0 |-> em_mask_ff.centre)
      else $error("nonzero code on a border result");

   a_emit_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> em_mask_ff == $past(em_mask_ff))
      else $error("pending results changed while output stalled");

endmodule
